### sv/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AVFET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define AVFET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/avfet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the escape-time fractal block.
// No dependencies; imported by every module of the block.
package avfet_pkg;

  // Fixed field widths
  localparam int unsigned IN_W      = 32;   // c_real / c_imag, Q4.28
  localparam int unsigned IN_FRAC   = 28;
  localparam int unsigned OUT_W     = 48;   // final_real / final_imag
  localparam int unsigned CNT_W     = 16;   // max_iter / iteration_count
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 16;

  localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd256;
  localparam logic [1:0]       EXTRA_ITERS  = 2'd2;   // iterations after escape

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMULA_MODE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    FM_BURNING_SHIP = 2'd0,
    FM_CELTIC       = 2'd1,
    FM_VARIANT      = 2'd2,
    FM_BIRD_OF_PREY = 2'd3
  } formula_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_COMB,
    ST_UPD,
    ST_DONE
  } core_state_e;

  // Request from the sequencer to the shared multiplier
  typedef struct packed {
    logic start;    // latch operands and begin a product
    logic square;   // a == b: skip the duplicate cross term
    logic abs_b;    // saturating absolute value of b before multiplying
  } mul_req_t;

endpackage

### sv/avfet_mul.sv
`timescale 1ns / 1ps
// Shared multi-cycle saturating fixed-point multiplier (half-word partial products).
// Depends on avfet_pkg.
module avfet_mul import avfet_pkg::*; #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mul_req_t                    req_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] p_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned H     = (W + 1) / 2;
  localparam int unsigned ACC_W = 2 * W;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] STEPS_SQ  = 3'd3;
  localparam logic [2:0] STEPS_GEN = 3'd4;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_HALF,
    SH_HALF_X2,
    SH_FULL
  } pp_shift_e;

  logic                 busy_q;
  logic [2:0]           cnt_q;
  logic [W-1:0]         a_q, b_q;
  logic                 neg_q, sq_q;
  logic [2*H-1:0]       pp_q;
  pp_shift_e            sh_q, sh_d;
  logic                 ppv_q;
  logic [ACC_W-1:0]     acc_q;
  logic signed [W-1:0]  p_q;
  logic                 done_q;

  logic [W-1:0]         a_mag, b_mag;
  logic                 neg_d;
  logic [2:0]           steps;
  logic                 issue, finish;
  logic [H-1:0]         a_lo, a_hi, b_lo, b_hi, op_a, op_b;
  logic [2*H-1:0]       prod;
  logic [ACC_W-1:0]     pp_ext;
  logic                 ovf;
  logic [W-2:0]         mag;
  logic signed [W-1:0]  sat_p;

  // Operand magnitudes and product sign
  always_comb begin
    a_mag = a_i[W-1] ? $unsigned(-a_i) : $unsigned(a_i);
    if (req_i.abs_b && (b_i == WMIN)) begin
      b_mag = $unsigned(WMAX);
    end else begin
      b_mag = b_i[W-1] ? $unsigned(-b_i) : $unsigned(b_i);
    end
    neg_d = req_i.abs_b ? a_i[W-1] : (a_i[W-1] ^ b_i[W-1]);
  end

  assign steps  = sq_q ? STEPS_SQ : STEPS_GEN;
  assign issue  = busy_q && (cnt_q < steps);
  assign finish = busy_q && (cnt_q == steps + 3'd1);

  assign a_lo = a_q[H-1:0];
  assign a_hi = H'(a_q[W-1:H]);
  assign b_lo = b_q[H-1:0];
  assign b_hi = H'(b_q[W-1:H]);

  // Partial product schedule
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin
        op_a = a_lo; op_b = b_lo; sh_d = SH_NONE;
      end
      2'd1: begin
        op_a = a_lo; op_b = b_hi; sh_d = sq_q ? SH_HALF_X2 : SH_HALF;
      end
      2'd2: begin
        op_a = sq_q ? a_hi : a_hi;
        op_b = sq_q ? b_hi : b_lo;
        sh_d = sq_q ? SH_FULL : SH_HALF;
      end
      default: begin
        op_a = a_hi; op_b = b_hi; sh_d = SH_FULL;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    unique case (sh_q)
      SH_NONE:    pp_ext = ACC_W'(pp_q);
      SH_HALF:    pp_ext = ACC_W'(pp_q) << H;
      SH_HALF_X2: pp_ext = ACC_W'(pp_q) << (H + 1);
      default:    pp_ext = ACC_W'(pp_q) << (2 * H);
    endcase
  end

  // Drop the fraction, saturate, apply sign
  always_comb begin
    ovf = |acc_q[ACC_W-1:F+W-1];
    mag = acc_q[F+W-2:F];
    if (ovf) begin
      sat_p = neg_q ? WMIN : WMAX;
    end else if (neg_q) begin
      sat_p = -$signed({1'b0, mag});
    end else begin
      sat_p = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ppv_q  <= issue;
      done_q <= finish;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (finish) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_mag;
      b_q   <= b_mag;
      neg_q <= neg_d;
      sq_q  <= req_i.square;
      acc_q <= '0;
    end else if (ppv_q) begin
      acc_q <= acc_q + pp_ext;
    end
    if (issue) begin
      pp_q <= prod;
      sh_q <= sh_d;
    end
    if (finish) begin
      p_q <= sat_p;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

### sv/avfet_core.sv
`timescale 1ns / 1ps
// Iteration sequencer: z state, formula combine, escape test and count.
// Depends on avfet_pkg; drives the shared avfet_mul unit.
module avfet_core import avfet_pkg::*; #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] cx_i,
  input  logic signed [WORD_BITS-1:0] cy_i,
  input  logic [CNT_W-1:0]            max_iter_i,
  input  formula_mode_e               mode_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [CNT_W-1:0]            count_o,
  output logic                        escaped_o,
  output logic signed [WORD_BITS-1:0] zr_o,
  output logic signed [WORD_BITS-1:0] zi_o,
  output mul_req_t                    mul_req_o,
  output logic signed [WORD_BITS-1:0] mul_a_o,
  output logic signed [WORD_BITS-1:0] mul_b_o,
  input  logic                        mul_done_i,
  input  logic signed [WORD_BITS-1:0] mul_p_i
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned F = FRAC_BITS;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W+3:0] ESC_LIM = {{(W+3){1'b0}}, 1'b1} << (F + 2);

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  core_state_e          state_q, state_d;
  logic signed [W-1:0]  x_q, y_q, cx_q, cy_q;
  logic signed [W-1:0]  re2_q, im2_q, p_q;
  logic [CNT_W:0]       count_q;
  logic [1:0]           extra_q;
  logic                 esc_q, escn_q;

  logic                 go;
  logic                 fold;
  logic signed [W-1:0]  diff, dsel, p_abs, p2;
  logic [W+3:0]         mag2;
  logic                 esc_now;

  assign go = esc_q ? (extra_q != 2'd0) : (count_q < {1'b0, max_iter_i});

  // Next state and multiplier requests
  always_comb begin
    state_d   = state_q;
    mul_req_o = '0;
    mul_a_o   = x_q;
    mul_b_o   = x_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (go) begin
          mul_req_o.start  = 1'b1;
          mul_req_o.square = 1'b1;
          state_d          = ST_XX;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_XX: begin
        mul_a_o          = y_q;
        mul_b_o          = y_q;
        mul_req_o.square = 1'b1;
        if (mul_done_i) begin
          mul_req_o.start = 1'b1;
          state_d         = ST_YY;
        end
      end
      ST_YY: begin
        mul_a_o         = x_q;
        mul_b_o         = y_q;
        mul_req_o.abs_b = (mode_i == FM_BIRD_OF_PREY);
        if (mul_done_i) begin
          mul_req_o.start = 1'b1;
          state_d         = ST_XY;
        end
      end
      ST_XY: begin
        if (mul_done_i) state_d = ST_COMB;
      end
      ST_COMB: state_d = ST_UPD;
      ST_UPD:  state_d = ST_CHECK;
      default: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
    endcase
  end

  // Formula combine: fold of the real part, doubled (Burning Ship: absolute) cross term, escape test
  always_comb begin
    fold = (mode_i == FM_CELTIC) || ((mode_i == FM_VARIANT) && count_q[0]);
    diff = re2_q - im2_q;
    dsel = (fold && diff[W-1]) ? -diff : diff;
    if ((mode_i == FM_BURNING_SHIP) && p_q[W-1]) begin
      p_abs = (p_q == WMIN) ? WMAX : -p_q;
    end else begin
      p_abs = p_q;
    end
    p2      = sat_add(p_abs, p_abs);
    mag2    = {4'b0000, re2_q} + {4'b0000, im2_q};
    esc_now = mag2 > ESC_LIM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      extra_q <= 2'd0;
      esc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_IDLE) && start_i) begin
        count_q <= (CNT_W+1)'(1);
        extra_q <= 2'd0;
        esc_q   <= 1'b0;
      end else if (state_q == ST_UPD) begin
        if (esc_q) begin
          extra_q <= extra_q - 2'd1;
          if (extra_q == EXTRA_ITERS) count_q <= count_q + (CNT_W+1)'(1);
        end else begin
          count_q <= count_q + (CNT_W+1)'(1);
          if (escn_q) begin
            esc_q   <= 1'b1;
            extra_q <= EXTRA_ITERS;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_q  <= cx_i;
          y_q  <= cy_i;
          cx_q <= cx_i;
          cy_q <= cy_i;
        end
      end
      ST_XX: begin
        if (mul_done_i) re2_q <= mul_p_i;
      end
      ST_YY: begin
        if (mul_done_i) im2_q <= mul_p_i;
      end
      ST_XY: begin
        if (mul_done_i) p_q <= mul_p_i;
      end
      ST_COMB: begin
        re2_q  <= dsel;
        p_q    <= p2;
        escn_q <= esc_now;
      end
      ST_UPD: begin
        x_q <= sat_add(re2_q, cx_q);
        y_q <= sat_add(p_q, cy_q);
      end
      default: begin
      end
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign count_o     = count_q[CNT_W] ? {CNT_W{1'b1}} : count_q[CNT_W-1:0];
  assign escaped_o   = esc_q;
  assign zr_o        = x_q;
  assign zi_o        = y_q;

endmodule

### sv/abs_variant_fractal_escape_time_top.sv
`timescale 1ns / 1ps
// Top level of the escape-time fractal block: config registers, input scaling,
// output register. Depends on avfet_pkg, avfet_core and avfet_mul.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   in       | in_valid_i / in_ready_o   | c_real_i, c_imag_i (Q4.28)
//   out      | out_valid_o / out_ready_i | iteration_count_o, escaped_o,
//            |                           | final_real_o, final_imag_o
//   cfg      | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// Each iteration runs three products (x*x, y*y, x*y) through a single half-word
// multiplier, plus the combine and update states and the loop test.
// in_ready_o is high only while the sequencer is idle; a finished result moves to
// the output register once it is empty or draining and waits there, so the next
// pixel may start while it waits.
// Reset clears config to max_iter 256, formula 0 and drops any transaction.
module abs_variant_fractal_escape_time_top import avfet_pkg::*; #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input transaction
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  c_real_i,
  input  logic signed [IN_W-1:0]  c_imag_i,
  // output transaction
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CNT_W-1:0]        iteration_count_o,
  output logic                    escaped_o,
  output logic signed [OUT_W-1:0] final_real_o,
  output logic signed [OUT_W-1:0] final_imag_o,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DW-1:0]       cfg_wdata_i
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  // Q4.28 -> internal format: scale up exactly or floor-shift down
  localparam int unsigned SHL = (F >= IN_FRAC) ? (F - IN_FRAC) : 0;
  localparam int unsigned SHR = (F <  IN_FRAC) ? (IN_FRAC - F) : 0;
  localparam int unsigned CW  = IN_W + 1 + SHL;
  localparam int unsigned XW  = CW + W;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] to_word(input logic signed [IN_W:0] v);
    logic signed [CW-1:0] wide;
    logic signed [XW-1:0] ext;
    wide = CW'(v);
    wide = wide <<< SHL;
    wide = wide >>> SHR;
    ext  = XW'(wide);
    if (ext > XW'(WMAX)) begin
      return WMAX;
    end else if (ext < XW'(WMIN)) begin
      return WMIN;
    end
    return W'(ext);
  endfunction

  // Config registers
  logic [CNT_W-1:0] max_iter_q;
  formula_mode_e    mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      mode_q     <= FM_BURNING_SHIP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_ITER:     max_iter_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_FORMULA_MODE: mode_q     <= formula_mode_e'(cfg_wdata_i[MODE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Convert and conjugate the pixel coordinate
  logic signed [IN_W:0] cr_ext, ci_ext, ci_neg;
  logic signed [W-1:0]  cx, cy;

  assign cr_ext = $signed({c_real_i[IN_W-1], c_real_i});
  assign ci_ext = $signed({c_imag_i[IN_W-1], c_imag_i});
  assign ci_neg = -ci_ext;
  assign cx     = to_word(cr_ext);
  assign cy     = to_word(ci_neg);

  // Sequencer and shared multiplier
  logic                core_idle, res_valid, res_ready;
  logic [CNT_W-1:0]    res_count;
  logic                res_esc;
  logic signed [W-1:0] res_zr, res_zi;
  mul_req_t            mul_req;
  logic signed [W-1:0] mul_a, mul_b, mul_p;
  logic                mul_done;

  assign in_ready_o = core_idle;

  avfet_core #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && core_idle),
    .cx_i        (cx),
    .cy_i        (cy),
    .max_iter_i  (max_iter_q),
    .mode_i      (mode_q),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .count_o     (res_count),
    .escaped_o   (res_esc),
    .zr_o        (res_zr),
    .zi_o        (res_zi),
    .mul_req_o   (mul_req),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_done_i  (mul_done),
    .mul_p_i     (mul_p)
  );

  avfet_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // Output register: take a result whenever the slot is empty or draining
  logic                    out_valid_q;
  logic [CNT_W-1:0]        count_q;
  logic                    esc_q;
  logic signed [OUT_W-1:0] zr_q, zi_q;

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold payload while the transaction waits; low OUT_W bits, sign-extended if narrower
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      count_q <= res_count;
      esc_q   <= res_esc;
      zr_q    <= OUT_W'(res_zr);
      zi_q    <= OUT_W'(res_zi);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = count_q;
  assign escaped_o         = esc_q;
  assign final_real_o      = zr_q;
  assign final_imag_o      = zi_q;

endmodule

### sv/avfet_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the escape-time fractal top, bound to it below.
// Depends on avfet_pkg and assert_macros.svh.
`include "assert_macros.svh"

module avfet_chk import avfet_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CNT_W-1:0] iteration_count_o,
  input logic             escaped_o
);

  // A stalled result holds
  `AVFET_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(iteration_count_o) && $stable(escaped_o), "stalled result changed")

  // One pixel at a time: ready drops right after a transaction is taken
  `AVFET_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // Escape needs one test iteration plus the two extra ones
  `AVFET_ASSERT_IMP(a_esc_count, clk_i, rst_ni, out_valid_o && escaped_o, iteration_count_o >= 16'd3, "escaped with count below three")

  // Count starts at one and never wraps to zero
  `AVFET_ASSERT_IMP(a_count_nz, clk_i, rst_ni, out_valid_o, iteration_count_o != 16'd0, "zero iteration count")

endmodule

bind abs_variant_fractal_escape_time_top avfet_chk u_avfet_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .iteration_count_o (iteration_count_o),
  .escaped_o         (escaped_o)
);
